// File: rtl/segtree_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the segment tree range sum unit
// no dependencies
package segtree_pkg;

  localparam int unsigned DEF_LEAVES = 1024;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned RANGE_W    = 11;

  // action codes of an input transaction
  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_QRY,
    ST_OUT
  } seg_state_e;

endpackage

// File: rtl/segment_tree_range_sum_unit.sv
`timescale 1ns / 1ps
// segment tree range sum unit, top level
// uses segtree_pkg, segtree_ctrl and segtree_mem
//
// usage
// - input channel (in_valid_i / in_stall_o): one transaction is either an add
//   (action 0: delta_i goes into leaf position_i and all of its ancestors) or a
//   query (action 1: sum of leaves in [range_start_i, range_end_i), clamped to
//   LEAVES, zero when empty). an add at or beyond LEAVES is dropped
// - output channel (out_valid_o / out_stall_i): one sum per query, none per add
// - after reset a clearing pass zeroes all 2*2^ceil(log2(LEAVES)) tree nodes,
//   one per cycle; in_stall_o stays high meanwhile
// - one transaction is worked at a time: an add does one memory read-modify-write
//   per tree level, with the parent read overlapped with the child write-back
// - a query works one level per cycle from acceptance on, using the two read
//   ports of the node memory, then waits to hand its sum to out_valid_o
// - the result sits in an output register; a stalled receiver holds it there
//   and new transactions are still taken, only a second query waits at its end
//   until that register is free
module segment_tree_range_sum_unit #(
  parameter int unsigned LEAVES = segtree_pkg::DEF_LEAVES
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   action_i,
  input  logic        [segtree_pkg::POS_W-1:0]   position_i,
  input  logic signed [segtree_pkg::SUM_W-1:0]   delta_i,
  input  logic        [segtree_pkg::RANGE_W-1:0] range_start_i,
  input  logic        [segtree_pkg::RANGE_W-1:0] range_end_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [segtree_pkg::SUM_W-1:0]   sum_o
);

  // node address: root at 1, leaves at 2^LVL .. 2^(LVL+1)-1
  localparam int unsigned AW = $clog2(LEAVES) + 1;
  localparam int unsigned DW = segtree_pkg::SUM_W;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_ra_addr;
  logic [AW-1:0] mem_rb_addr;
  logic [DW-1:0] mem_ra_data;
  logic [DW-1:0] mem_rb_data;

  segtree_ctrl #(
    .LEAVES (LEAVES),
    .AW     (AW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .position_i    (position_i),
    .delta_i       (delta_i),
    .range_start_i (range_start_i),
    .range_end_i   (range_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sum_o         (sum_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_ra_addr_o (mem_ra_addr),
    .mem_rb_addr_o (mem_rb_addr),
    .mem_ra_data_i (mem_ra_data),
    .mem_rb_data_i (mem_rb_data)
  );

  // node sums, cleared by the sequencer after reset
  segtree_mem #(
    .AW (AW),
    .DW (DW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .ra_addr_i (mem_ra_addr),
    .rb_addr_i (mem_rb_addr),
    .ra_data_o (mem_ra_data),
    .rb_data_o (mem_rb_data)
  );

endmodule

// File: rtl/segtree_mem.sv
`timescale 1ns / 1ps
// node sum memory: one write port, two read ports, registered read data
// depends on nothing but its parameters
module segtree_mem #(
  parameter int unsigned AW = 11,
  parameter int unsigned DW = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] ra_addr_i,
  input  logic [AW-1:0] rb_addr_i,
  output logic [DW-1:0] ra_data_o,
  output logic [DW-1:0] rb_data_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] ra_data_q;
  logic [DW-1:0] rb_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    ra_data_q <= mem_q[ra_addr_i];
    rb_data_q <= mem_q[rb_addr_i];
  end

  assign ra_data_o = ra_data_q;
  assign rb_data_o = rb_data_q;

endmodule

// File: rtl/segtree_ctrl.sv
`timescale 1ns / 1ps
// sequencer of the segment tree: clearing pass, leaf-to-root update, bottom-up query
// uses segtree_pkg; drives the ports of segtree_mem
module segtree_ctrl #(
  parameter int unsigned LEAVES = segtree_pkg::DEF_LEAVES,
  parameter int unsigned AW     = $clog2(LEAVES) + 1
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic                                     action_i,
  input  logic        [segtree_pkg::POS_W-1:0]     position_i,
  input  logic signed [segtree_pkg::SUM_W-1:0]     delta_i,
  input  logic        [segtree_pkg::RANGE_W-1:0]   range_start_i,
  input  logic        [segtree_pkg::RANGE_W-1:0]   range_end_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [segtree_pkg::SUM_W-1:0]     sum_o,
  output logic                                     mem_we_o,
  output logic        [AW-1:0]                     mem_waddr_o,
  output logic        [segtree_pkg::SUM_W-1:0]     mem_wdata_o,
  output logic        [AW-1:0]                     mem_ra_addr_o,
  output logic        [AW-1:0]                     mem_rb_addr_o,
  input  logic        [segtree_pkg::SUM_W-1:0]     mem_ra_data_i,
  input  logic        [segtree_pkg::SUM_W-1:0]     mem_rb_data_i
);

  localparam int unsigned LVL  = AW - 1;
  localparam int unsigned NW   = AW + 1;
  localparam int unsigned SPAN = 1 << LVL;
  localparam int unsigned DW   = segtree_pkg::SUM_W;

  segtree_pkg::seg_state_e state_q, state_d;

  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] node_q, node_d;
  logic [DW-1:0] delta_q, delta_d;
  logic [NW-1:0] l_q, l_d;
  logic [NW-1:0] r_q, r_d;
  logic [DW-1:0] acc_q, acc_d;
  logic          pa_q, pa_d;
  logic          pb_q, pb_d;
  logic          out_valid_q, out_valid_d;
  logic [DW-1:0] sum_q, sum_d;

  logic          pos_ok;
  logic [31:0]   lo_c;
  logic [31:0]   hi_c;
  logic [NW-1:0] l_adv;
  logic [NW-1:0] r_adv;
  logic          out_free;

  assign pos_ok   = (32'(position_i) < LEAVES);
  assign lo_c     = (32'(range_start_i) > LEAVES) ? LEAVES : 32'(range_start_i);
  assign hi_c     = (32'(range_end_i) > LEAVES) ? LEAVES : 32'(range_end_i);
  assign l_adv    = l_q + NW'(l_q[0]);
  assign r_adv    = r_q - NW'(r_q[0]);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    node_d      = node_q;
    delta_d     = delta_q;
    l_d         = l_q;
    r_d         = r_q;
    acc_d       = acc_q;
    pa_d        = 1'b0;
    pb_d        = 1'b0;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && out_stall_i;

    in_stall_o    = 1'b1;
    mem_we_o      = 1'b0;
    mem_waddr_o   = node_q;
    mem_wdata_o   = mem_ra_data_i + delta_q;
    mem_ra_addr_o = node_q;
    mem_rb_addr_o = r_adv[AW-1:0];

    case (state_q)
      segtree_pkg::ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = '0;
        clr_d       = clr_q + AW'(1);
        if (&clr_q) begin
          state_d = segtree_pkg::ST_IDLE;
        end
      end
      segtree_pkg::ST_IDLE: begin
        // stall is low here, so a valid transaction is taken at this edge
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (action_i == segtree_pkg::ACT_QUERY) begin
            l_d     = NW'(lo_c + SPAN);
            r_d     = NW'(hi_c + SPAN);
            acc_d   = '0;
            state_d = segtree_pkg::ST_QRY;
          end else if (pos_ok) begin
            node_d  = AW'(32'(position_i) + SPAN);
            delta_d = delta_i;
            state_d = segtree_pkg::ST_ADD_RD;
          end
        end
      end
      segtree_pkg::ST_ADD_RD: begin
        // read of the leaf, its data arrives next cycle
        mem_ra_addr_o = node_q;
        state_d       = segtree_pkg::ST_ADD_WR;
      end
      segtree_pkg::ST_ADD_WR: begin
        // write back this node and fetch its parent in the same cycle
        mem_we_o      = 1'b1;
        mem_ra_addr_o = node_q >> 1;
        node_d        = node_q >> 1;
        if (node_q == AW'(1)) begin
          state_d = segtree_pkg::ST_IDLE;
        end
      end
      segtree_pkg::ST_QRY: begin
        // fold the reads issued in the previous cycle
        acc_d = acc_q + (pa_q ? mem_ra_data_i : '0) + (pb_q ? mem_rb_data_i : '0);
        mem_ra_addr_o = l_q[AW-1:0];
        if (l_q < r_q) begin
          pa_d = l_q[0];
          pb_d = r_q[0];
          l_d  = l_adv >> 1;
          r_d  = r_adv >> 1;
        end else begin
          state_d = segtree_pkg::ST_OUT;
        end
      end
      segtree_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          sum_d       = acc_q;
          state_d     = segtree_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = segtree_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= segtree_pkg::ST_CLEAR;
      clr_q       <= '0;
      pa_q        <= 1'b0;
      pb_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pa_q        <= pa_d;
      pb_q        <= pb_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    delta_q <= delta_d;
    l_q     <= l_d;
    r_q     <= r_d;
    acc_q   <= acc_d;
    sum_q   <= sum_d;
  end

  assign out_valid_o = out_valid_q;
  assign sum_o       = sum_q;

endmodule

// File: rtl/segtree_chk.sv
`timescale 1ns / 1ps
// port-level checker of the segment tree range sum unit, bound to the top level
// uses segtree_pkg for field widths
module segtree_chk (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_stall_o,
  input logic                                   action_i,
  input logic        [segtree_pkg::POS_W-1:0]   position_i,
  input logic signed [segtree_pkg::SUM_W-1:0]   delta_i,
  input logic        [segtree_pkg::RANGE_W-1:0] range_start_i,
  input logic        [segtree_pkg::RANGE_W-1:0] range_end_i,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic signed [segtree_pkg::SUM_W-1:0]   sum_o
);

  // stalled result transaction stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // stalled result payload holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(sum_o))
    else $error("result changed while stalled");

  // clearing pass blocks input right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("input taken during clearing pass");

  // a new result only appears at the end of busy work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a query in progress");

  // an add transaction never yields a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == segtree_pkg::ACT_ADD) && !out_valid_o
    |=> !out_valid_o)
    else $error("result after an add");

endmodule

bind segment_tree_range_sum_unit segtree_chk u_chk (.*);
